// ----- design/kbhv_pkg.sv -----
// package with types and codes for the key blob header validator
`default_nettype none

package kbhv_pkg;

  typedef enum logic [2:0] {
    PH_ALG       = 3'd0,
    PH_LEVEL     = 3'd1,
    PH_LEN_FIRST = 3'd2,
    PH_LEN_EXT   = 3'd3,
    PH_PAYLOAD   = 3'd4,
    PH_ERROR     = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TRUNC        = 3'd1,
    ST_BAD_ALG      = 3'd2,
    ST_BAD_LEVEL    = 3'd3,
    ST_NONMIN       = 3'd4,
    ST_LEN_MISMATCH = 3'd5,
    ST_PAYLOAD_SIZE = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    LVL_SMALL  = 2'd0,
    LVL_MEDIUM = 2'd1,
    LVL_LARGE  = 2'd2
  } level_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_U16  = 2'd1,
    KIND_U32  = 2'd2,
    KIND_U64  = 2'd3
  } len_kind_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_ALGORITHM_CODE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_CODE_SMALL  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_CODE_MEDIUM = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_CODE_LARGE  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_SIZE_SMALL    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_SIZE_MEDIUM   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_SIZE_LARGE    = 3'd6;

  localparam logic [7:0] PREFIX_U16 = 8'hFD;
  localparam logic [7:0] PREFIX_BASE = 8'hFC;

  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

endpackage

`default_nettype wire

// ----- design/key_blob_header_validator.sv -----
// Key blob header validator: checks algorithm, level and CompactSize length
//
// Input beats carry one blob byte each on s_tdata[7:0]; s_tlast marks the
// final byte of a blob. Each accepted byte updates the parser state in the
// same cycle and, if it produces a result, loads the output register.
// A result beat is sent for every passed key byte (m_tuser = 1) and for
// every last byte (m_tlast = 1, verdict in key_ok, level and status).
// Throughput is one byte per cycle while m_tready is high; the single
// output register is the only buffer, so s_tready follows m_tready while a
// result is held. Registers are to be written by the user through cfg_wr_en,
// cfg_index and cfg_wdata only while the block is idle; the block does not
// enforce this. Writes to an index beyond the list are ignored. Synchronous
// reset restores register defaults, returns the parser to the algorithm
// byte and empties the output register. After each verdict the parser
// returns to the algorithm byte on its own.
`default_nettype none

module key_blob_header_validator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] blob_byte
  input  wire logic        s_tlast,
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [15:0] m_tdata,   // [7:0] payload_byte, [8] key_ok, [10:9] level,
                                      // [13:11] status, [15:14] zero
  output      logic        m_tuser,   // [0] payload_valid
  output      logic        m_tlast,   // done_res
  input  wire logic                               cfg_wr_en,
  input  wire logic [kbhv_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [kbhv_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // configuration registers
  logic [7:0]  algorithm_code;
  logic [7:0]  level_code_small;
  logic [7:0]  level_code_medium;
  logic [7:0]  level_code_large;
  logic [15:0] key_size_small;
  logic [15:0] key_size_medium;
  logic [15:0] key_size_large;

  always_ff @(posedge clk) begin
    if (rst) begin
      algorithm_code    <= 8'd0;
      level_code_small  <= 8'd0;
      level_code_medium <= 8'd1;
      level_code_large  <= 8'd2;
      key_size_small    <= 16'd1312;
      key_size_medium   <= 16'd1952;
      key_size_large    <= 16'd2592;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        kbhv_pkg::REG_ALGORITHM_CODE:    algorithm_code    <= cfg_wdata[7:0];
        kbhv_pkg::REG_LEVEL_CODE_SMALL:  level_code_small  <= cfg_wdata[7:0];
        kbhv_pkg::REG_LEVEL_CODE_MEDIUM: level_code_medium <= cfg_wdata[7:0];
        kbhv_pkg::REG_LEVEL_CODE_LARGE:  level_code_large  <= cfg_wdata[7:0];
        kbhv_pkg::REG_KEY_SIZE_SMALL:    key_size_small    <= cfg_wdata;
        kbhv_pkg::REG_KEY_SIZE_MEDIUM:   key_size_medium   <= cfg_wdata;
        kbhv_pkg::REG_KEY_SIZE_LARGE:    key_size_large    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // parser state
  kbhv_pkg::phase_t    phase, phase_next;
  kbhv_pkg::len_kind_t len_kind, len_kind_next;
  logic [2:0]          len_idx, len_idx_next;
  logic [15:0]         len_low, len_low_next;
  logic                len_mid_nz, len_mid_nz_next;   // bits 31:16 nonzero
  logic                len_top_nz, len_top_nz_next;   // bits 63:32 nonzero
  kbhv_pkg::level_t    level_index, level_index_next;
  kbhv_pkg::status_t   first_error, first_error_next;
  logic [16:0]         payload_count, payload_count_next;

  // output register
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_pv;
  logic        out_done;
  logic        out_ok;
  logic [1:0]  out_level;
  logic [2:0]  out_status;

  // per-beat result
  logic              res_pv;
  logic              res_emit;
  logic              res_ok;
  kbhv_pkg::status_t res_status;

  logic accept;
  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  logic [15:0] level_size;
  always_comb begin
    case (level_index)
      kbhv_pkg::LVL_SMALL:  level_size = key_size_small;
      kbhv_pkg::LVL_MEDIUM: level_size = key_size_medium;
      default:              level_size = key_size_large;
    endcase
  end

  logic [2:0] ext_last_idx;
  always_comb begin
    case (len_kind)
      kbhv_pkg::KIND_U16: ext_last_idx = 3'd1;
      kbhv_pkg::KIND_U32: ext_last_idx = 3'd3;
      default:            ext_last_idx = 3'd7;
    endcase
  end

  // next state
  always_comb begin
    logic [7:0] b;
    logic       minimal;
    b                  = s_tdata;
    minimal            = 1'b0;
    phase_next         = phase;
    len_kind_next      = len_kind;
    len_idx_next       = len_idx;
    len_low_next       = len_low;
    len_mid_nz_next    = len_mid_nz;
    len_top_nz_next    = len_top_nz;
    level_index_next   = level_index;
    first_error_next   = first_error;
    payload_count_next = payload_count;
    res_pv             = 1'b0;
    case (phase)
      kbhv_pkg::PH_ALG: begin
        if (b != algorithm_code) begin
          first_error_next = kbhv_pkg::ST_BAD_ALG;
          phase_next       = kbhv_pkg::PH_ERROR;
        end else begin
          phase_next = kbhv_pkg::PH_LEVEL;
        end
      end
      kbhv_pkg::PH_LEVEL: begin
        phase_next = kbhv_pkg::PH_LEN_FIRST;
        if (b == level_code_small) begin
          level_index_next = kbhv_pkg::LVL_SMALL;
        end else if (b == level_code_medium) begin
          level_index_next = kbhv_pkg::LVL_MEDIUM;
        end else if (b == level_code_large) begin
          level_index_next = kbhv_pkg::LVL_LARGE;
        end else begin
          first_error_next = kbhv_pkg::ST_BAD_LEVEL;
          phase_next       = kbhv_pkg::PH_ERROR;
        end
      end
      kbhv_pkg::PH_LEN_FIRST: begin
        len_mid_nz_next = 1'b0;
        len_top_nz_next = 1'b0;
        if (b < kbhv_pkg::PREFIX_U16) begin
          len_low_next = {8'd0, b};
          if ({8'd0, b} != level_size) begin
            first_error_next = kbhv_pkg::ST_LEN_MISMATCH;
            phase_next       = kbhv_pkg::PH_ERROR;
          end else begin
            phase_next         = kbhv_pkg::PH_PAYLOAD;
            payload_count_next = 17'd0;
          end
        end else begin
          len_kind_next = kbhv_pkg::len_kind_t'(2'(b - kbhv_pkg::PREFIX_BASE));
          len_idx_next  = 3'd0;
          len_low_next  = 16'd0;
          phase_next    = kbhv_pkg::PH_LEN_EXT;
        end
      end
      kbhv_pkg::PH_LEN_EXT: begin
        if (len_idx[2]) begin
          len_top_nz_next = len_top_nz || (b != 8'd0);
        end else if (len_idx[1]) begin
          len_mid_nz_next = len_mid_nz || (b != 8'd0);
        end else if (len_idx[0]) begin
          len_low_next[15:8] = b;
        end else begin
          len_low_next[7:0] = b;
        end
        len_idx_next = len_idx + 3'd1;
        if (len_idx == ext_last_idx) begin
          case (len_kind)
            kbhv_pkg::KIND_U16: minimal = len_low_next >= {8'd0, kbhv_pkg::PREFIX_U16};
            kbhv_pkg::KIND_U32: minimal = len_mid_nz_next;
            default:            minimal = len_top_nz_next;
          endcase
          if (!minimal) begin
            first_error_next = kbhv_pkg::ST_NONMIN;
            phase_next       = kbhv_pkg::PH_ERROR;
          end else if (len_mid_nz_next || len_top_nz_next || len_low_next != level_size) begin
            first_error_next = kbhv_pkg::ST_LEN_MISMATCH;
            phase_next       = kbhv_pkg::PH_ERROR;
          end else begin
            phase_next         = kbhv_pkg::PH_PAYLOAD;
            payload_count_next = 17'd0;
          end
        end
      end
      kbhv_pkg::PH_PAYLOAD: begin
        if (payload_count >= {1'b0, len_low}) begin
          first_error_next = kbhv_pkg::ST_PAYLOAD_SIZE;
          phase_next       = kbhv_pkg::PH_ERROR;
        end else begin
          if (payload_count != kbhv_pkg::COUNT_MAX) begin
            payload_count_next = payload_count + 17'd1;
          end
          res_pv = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // verdict for this beat
  always_comb begin
    res_emit = res_pv || s_tlast;
    if (first_error_next != kbhv_pkg::ST_OK) begin
      res_status = first_error_next;
    end else if (phase_next != kbhv_pkg::PH_PAYLOAD) begin
      res_status = kbhv_pkg::ST_TRUNC;
    end else if (payload_count_next != {1'b0, len_low_next}) begin
      res_status = kbhv_pkg::ST_PAYLOAD_SIZE;
    end else begin
      res_status = kbhv_pkg::ST_OK;
    end
    res_ok = res_status == kbhv_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= kbhv_pkg::PH_ALG;
      len_kind      <= kbhv_pkg::KIND_NONE;
      len_idx       <= 3'd0;
      len_low       <= 16'd0;
      len_mid_nz    <= 1'b0;
      len_top_nz    <= 1'b0;
      level_index   <= kbhv_pkg::LVL_SMALL;
      first_error   <= kbhv_pkg::ST_OK;
      payload_count <= 17'd0;
    end else if (accept) begin
      if (s_tlast) begin
        phase         <= kbhv_pkg::PH_ALG;
        len_kind      <= kbhv_pkg::KIND_NONE;
        len_idx       <= 3'd0;
        len_low       <= 16'd0;
        len_mid_nz    <= 1'b0;
        len_top_nz    <= 1'b0;
        level_index   <= kbhv_pkg::LVL_SMALL;
        first_error   <= kbhv_pkg::ST_OK;
        payload_count <= 17'd0;
      end else begin
        phase         <= phase_next;
        len_kind      <= len_kind_next;
        len_idx       <= len_idx_next;
        len_low       <= len_low_next;
        len_mid_nz    <= len_mid_nz_next;
        len_top_nz    <= len_top_nz_next;
        level_index   <= level_index_next;
        first_error   <= first_error_next;
        payload_count <= payload_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_emit;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_emit) begin
      out_byte   <= res_pv ? s_tdata : 8'd0;
      out_pv     <= res_pv;
      out_done   <= s_tlast;
      out_ok     <= s_tlast && res_ok;
      out_level  <= s_tlast ? level_index_next : 2'd0;
      out_status <= s_tlast ? res_status : kbhv_pkg::ST_OK;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_status, out_level, out_ok, out_byte};
  assign m_tuser  = out_pv;
  assign m_tlast  = out_done;

`ifndef ASSERT_OFF
  a_ok_means_status_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_ok) |-> (out_done && out_status == kbhv_pkg::ST_OK))
    else $error("key_ok set without a clean verdict");

  a_no_verdict_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_done) |-> (out_pv && out_status == kbhv_pkg::ST_OK && out_level == 2'd0))
    else $error("non-verdict beat carries verdict fields or no key byte");

  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> (phase == kbhv_pkg::PH_ALG && first_error == kbhv_pkg::ST_OK))
    else $error("parser did not restart after a verdict");

  a_error_recorded: assert property (@(posedge clk) disable iff (rst)
    (phase == kbhv_pkg::PH_ERROR) |-> (first_error != kbhv_pkg::ST_OK))
    else $error("error phase without a recorded error");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/kbhv_stream_checker.sv -----
// stream checker for the key blob header validator: predicts result beats and compares them
`default_nettype none

module kbhv_stream_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  input  wire logic                             s_tready,
  input  wire logic [7:0]                       s_tdata,
  input  wire logic                             s_tlast,
  input  wire logic                             m_tvalid,
  input  wire logic                             m_tready,
  input  wire logic [15:0]                      m_tdata,
  input  wire logic                             m_tuser,
  input  wire logic                             m_tlast,
  input  wire logic                             cfg_wr_en,
  input  wire logic [kbhv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [kbhv_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                                    mismatches,
  output int                                    beats_due
);

  typedef struct packed {
    logic [7:0]        payload_byte;
    logic              payload_valid;
    logic              done_res;
    logic              key_ok;
    kbhv_pkg::level_t  level;
    kbhv_pkg::status_t status;
  } beat_t;

  logic [7:0]  alg_code;
  logic [7:0]  lvl_code [3];
  logic [15:0] key_size [3];

  kbhv_pkg::phase_t    ph;
  logic [3:0]          len_left;
  kbhv_pkg::len_kind_t len_kind;
  logic [63:0]         len_val;
  kbhv_pkg::level_t    lvl_idx;
  kbhv_pkg::status_t   err;
  logic [16:0]         pay_cnt;

  beat_t due_beats [$];
  beat_t want;
  int    bad_count = 0;

  function automatic void clear_parser();
    ph       = kbhv_pkg::PH_ALG;
    len_left = '0;
    len_kind = kbhv_pkg::KIND_NONE;
    len_val  = '0;
    lvl_idx  = kbhv_pkg::LVL_SMALL;
    err      = kbhv_pkg::ST_OK;
    pay_cnt  = '0;
  endfunction

  function automatic void record_error(input kbhv_pkg::status_t code);
    if (err == kbhv_pkg::ST_OK) err = code;
    ph = kbhv_pkg::PH_ERROR;
  endfunction

  function automatic logic [3:0] ext_bytes(input kbhv_pkg::len_kind_t k);
    case (k)
      kbhv_pkg::KIND_U16: return 4'd2;
      kbhv_pkg::KIND_U32: return 4'd4;
      default:            return 4'd8;
    endcase
  endfunction

  function automatic void finish_length();
    if (len_val != 64'(key_size[lvl_idx])) begin
      record_error(kbhv_pkg::ST_LEN_MISMATCH);
    end else begin
      ph      = kbhv_pkg::PH_PAYLOAD;
      pay_cnt = '0;
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic lst);
    beat_t             nb;
    logic              pv;
    logic              minimal;
    logic [3:0]        pos;
    kbhv_pkg::status_t verdict;
    pv = 1'b0;
    case (ph)
      kbhv_pkg::PH_ALG: begin
        if (b != alg_code) record_error(kbhv_pkg::ST_BAD_ALG);
        else ph = kbhv_pkg::PH_LEVEL;
      end
      kbhv_pkg::PH_LEVEL: begin
        if (b == lvl_code[0]) begin
          lvl_idx = kbhv_pkg::LVL_SMALL;
          ph = kbhv_pkg::PH_LEN_FIRST;
        end else if (b == lvl_code[1]) begin
          lvl_idx = kbhv_pkg::LVL_MEDIUM;
          ph = kbhv_pkg::PH_LEN_FIRST;
        end else if (b == lvl_code[2]) begin
          lvl_idx = kbhv_pkg::LVL_LARGE;
          ph = kbhv_pkg::PH_LEN_FIRST;
        end else begin
          record_error(kbhv_pkg::ST_BAD_LEVEL);
        end
      end
      kbhv_pkg::PH_LEN_FIRST: begin
        if (b < kbhv_pkg::PREFIX_U16) begin
          len_val = 64'(b);
          finish_length();
        end else begin
          len_kind = kbhv_pkg::len_kind_t'(2'(b - kbhv_pkg::PREFIX_BASE));
          len_left = ext_bytes(len_kind);
          len_val  = '0;
          ph       = kbhv_pkg::PH_LEN_EXT;
        end
      end
      kbhv_pkg::PH_LEN_EXT: begin
        pos      = (ext_bytes(len_kind) - len_left) & 4'd7;
        len_val  = len_val | (64'(b) << (8 * pos));
        len_left = len_left - 4'd1;
        if (len_left == 4'd0) begin
          case (len_kind)
            kbhv_pkg::KIND_U16: minimal = len_val >= 64'(kbhv_pkg::PREFIX_U16);
            kbhv_pkg::KIND_U32: minimal = len_val > 64'hFFFF;
            default:            minimal = len_val > 64'hFFFF_FFFF;
          endcase
          if (!minimal) record_error(kbhv_pkg::ST_NONMIN);
          else finish_length();
        end
      end
      kbhv_pkg::PH_PAYLOAD: begin
        if (64'(pay_cnt) >= len_val) begin
          record_error(kbhv_pkg::ST_PAYLOAD_SIZE);
        end else begin
          if (pay_cnt != kbhv_pkg::COUNT_MAX) pay_cnt = pay_cnt + 17'd1;
          pv = 1'b1;
        end
      end
      default: ;
    endcase

    if (pv || lst) begin
      nb = '0;
      nb.payload_byte  = pv ? b : 8'h00;
      nb.payload_valid = pv;
      if (lst) begin
        if (err != kbhv_pkg::ST_OK) verdict = err;
        else if (ph != kbhv_pkg::PH_PAYLOAD) verdict = kbhv_pkg::ST_TRUNC;
        else if (64'(pay_cnt) != len_val) verdict = kbhv_pkg::ST_PAYLOAD_SIZE;
        else verdict = kbhv_pkg::ST_OK;
        nb.done_res = 1'b1;
        nb.key_ok   = (verdict == kbhv_pkg::ST_OK);
        nb.level    = lvl_idx;
        nb.status   = verdict;
        clear_parser();
      end
      due_beats.push_back(nb);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      alg_code    = 8'h00;
      lvl_code[0] = 8'h00;
      lvl_code[1] = 8'h01;
      lvl_code[2] = 8'h02;
      key_size[0] = 16'd1312;
      key_size[1] = 16'd1952;
      key_size[2] = 16'd2592;
      clear_parser();
      due_beats.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (due_beats.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("mismatch: result beat with none due, tdata %h tuser %b tlast %b",
                     m_tdata, m_tuser, m_tlast);
        end else begin
          want = due_beats.pop_front();
          if (m_tdata[7:0] !== want.payload_byte || m_tuser !== want.payload_valid ||
              m_tlast !== want.done_res || m_tdata[8] !== want.key_ok ||
              m_tdata[10:9] !== want.level || m_tdata[13:11] !== want.status ||
              m_tdata[15:14] !== 2'b00) begin
            bad_count++;
            if (bad_count <= 10)
              $display({"mismatch: exp byte %h pv %b done %b ok %b lvl %0d st %0d, ",
                        "got byte %h pv %b done %b ok %b lvl %0d st %0d pad %b"},
                       want.payload_byte, want.payload_valid, want.done_res, want.key_ok,
                       want.level, want.status, m_tdata[7:0], m_tuser, m_tlast, m_tdata[8],
                       m_tdata[10:9], m_tdata[13:11], m_tdata[15:14]);
          end
        end
      end
      if (s_tvalid && s_tready) parse_byte(s_tdata, s_tlast);
      if (cfg_wr_en) begin
        case (cfg_index)
          kbhv_pkg::REG_ALGORITHM_CODE:    alg_code    = cfg_wdata[7:0];
          kbhv_pkg::REG_LEVEL_CODE_SMALL:  lvl_code[0] = cfg_wdata[7:0];
          kbhv_pkg::REG_LEVEL_CODE_MEDIUM: lvl_code[1] = cfg_wdata[7:0];
          kbhv_pkg::REG_LEVEL_CODE_LARGE:  lvl_code[2] = cfg_wdata[7:0];
          kbhv_pkg::REG_KEY_SIZE_SMALL:    key_size[0] = cfg_wdata;
          kbhv_pkg::REG_KEY_SIZE_MEDIUM:   key_size[1] = cfg_wdata;
          kbhv_pkg::REG_KEY_SIZE_LARGE:    key_size[2] = cfg_wdata;
          default: ;
        endcase
      end
    end
    mismatches <= bad_count;
    beats_due  <= due_beats.size();
  end

endmodule

`default_nettype wire

// ----- tb/sv/tb_key_blob_header_validator.sv -----
// testbench top for the key blob header validator: clock, reset, blob stimulus and verdict
`default_nettype none

module tb_key_blob_header_validator;

  localparam logic [kbhv_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 150;
  localparam int SETTLE       = 4;
  localparam int RANDOM_ITEMS = 1400;
  localparam int PHASE_ITEMS  = 160;

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [7:0]                       s_tdata = 8'h00;
  logic                             s_tlast = 1'b0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [15:0]                      m_tdata;
  logic                             m_tuser;
  logic                             m_tlast;
  logic                             cfg_wr_en = 1'b0;
  logic [kbhv_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [kbhv_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  int mismatches;
  int beats_due;
  int cycles = 0;
  int items_sent = 0;
  int burst_left = 0;
  bit calm = 1'b0;
  int holds_asked = 0;
  int holds_done = 0;

  logic [7:0]  alg_cfg = 8'h00;
  logic [7:0]  lvl_cfg [3] = '{8'h00, 8'h01, 8'h02};
  logic [15:0] size_cfg [3] = '{16'd1312, 16'd1952, 16'd2592};
  logic [7:0]  blob_q [$];

  key_blob_header_validator DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  kbhv_stream_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .beats_due(beats_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // receiver: changing ready patterns plus requested long hold-offs
  initial begin
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (holds_asked != holds_done) begin
        holds_done++;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 150);
      end
      mode_left--;
      case (mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= mode_left[2];
      endcase
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic l);
    int gap;
    if (burst_left == 0) begin
      gap = calm ? 0 : $urandom_range(0, 6);
      burst_left = calm ? 200 : $urandom_range(1, 24);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic send_blob();
    for (int i = 0; i < blob_q.size(); i++) send_beat(blob_q[i], i == blob_q.size() - 1);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (beats_due != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic put_reg(input logic [kbhv_pkg::CFG_INDEX_W-1:0] idx,
                         input logic [kbhv_pkg::CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] a, ls, lm, ll, input logic [15:0] ks, km, kl);
    drain();
    alg_cfg     = a;
    lvl_cfg[0]  = ls;
    lvl_cfg[1]  = lm;
    lvl_cfg[2]  = ll;
    size_cfg[0] = ks;
    size_cfg[1] = km;
    size_cfg[2] = kl;
    put_reg(REG_UNUSED, 16'($urandom));
    put_reg(kbhv_pkg::REG_ALGORITHM_CODE, {8'($urandom), a});
    put_reg(kbhv_pkg::REG_LEVEL_CODE_SMALL, {8'($urandom), ls});
    put_reg(kbhv_pkg::REG_LEVEL_CODE_MEDIUM, {8'($urandom), lm});
    put_reg(kbhv_pkg::REG_LEVEL_CODE_LARGE, {8'($urandom), ll});
    put_reg(kbhv_pkg::REG_KEY_SIZE_SMALL, ks);
    put_reg(kbhv_pkg::REG_KEY_SIZE_MEDIUM, km);
    put_reg(kbhv_pkg::REG_KEY_SIZE_LARGE, kl);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic int min_form(input logic [63:0] v);
    if (v < 64'(kbhv_pkg::PREFIX_U16)) return 0;
    if (v <= 64'hFFFF) return 1;
    if (v <= 64'hFFFF_FFFF) return 2;
    return 3;
  endfunction

  function automatic void add_length(input logic [63:0] v, input int form);
    if (form == 0) begin
      blob_q.push_back(v[7:0]);
    end else begin
      blob_q.push_back(kbhv_pkg::PREFIX_BASE + 8'(form));
      for (int i = 0; i < (1 << form); i++) blob_q.push_back(v[8*i +: 8]);
    end
  endfunction

  function automatic void add_noise(input int most);
    repeat ($urandom_range(0, most)) blob_q.push_back(8'($urandom));
  endfunction

  function automatic logic [15:0] pick_size();
    case ($urandom_range(0, 13))
      0: return 16'd252;
      1: return 16'd253;
      2: return 16'd256;
      3: return 16'hFFFF;
      4: return 16'($urandom);
      default: return 16'($urandom_range(0, 30));
    endcase
  endfunction

  // mostly well-formed blobs; the rest break one rule or stop early
  function automatic void make_blob();
    int pick;
    int lv;
    int form;
    int n;
    int cut;
    logic [7:0]  lb;
    logic [63:0] len;
    pick = $urandom_range(0, 99);
    blob_q.delete();
    if (pick >= 79 && pick < 86) begin
      blob_q.push_back(alg_cfg ^ 8'($urandom_range(1, 255)));
      add_noise(4);
      return;
    end
    blob_q.push_back(alg_cfg);
    if (pick >= 86 && pick < 92) begin
      do lb = 8'($urandom); while (lb == lvl_cfg[0] || lb == lvl_cfg[1] || lb == lvl_cfg[2]);
      blob_q.push_back(lb);
      add_noise(3);
      return;
    end
    lb = lvl_cfg[$urandom_range(0, 2)];
    blob_q.push_back(lb);
    lv = (lb == lvl_cfg[0]) ? 0 : (lb == lvl_cfg[1]) ? 1 : 2;
    len = 64'(size_cfg[lv]);
    form = min_form(len);
    if (pick >= 65 && pick < 72 && form < 3) begin
      form = $urandom_range(form + 1, 3);
    end else if (pick >= 72 && pick < 79) begin
      do begin
        if ($urandom_range(0, 1) == 1) len = 64'(size_cfg[lv]) + 64'($urandom_range(1, 3));
        else len = {$urandom, $urandom} >> $urandom_range(0, 63);
      end while (len == 64'(size_cfg[lv]));
      form = min_form(len);
    end
    add_length(len, form);
    if (pick >= 92) begin
      cut = $urandom_range(1, blob_q.size() - 1);
      while (blob_q.size() > cut) void'(blob_q.pop_back());
      return;
    end
    if (pick >= 65) begin
      add_noise(3);
      return;
    end
    n = int'(len);
    if (n > 40 && !(n <= 300 && $urandom_range(0, 3) == 0)) n = $urandom_range(0, 6);
    else if ($urandom_range(0, 9) == 0) n = ($urandom_range(0, 1) == 1 && n > 0) ? n - 1 : n + 1;
    repeat (n) blob_q.push_back(8'($urandom));
  endfunction

  initial begin
    int goal;
    int phase_end;
    int phase_no;
    logic [7:0] ls;
    logic [7:0] lm;
    logic [7:0] ll;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: level large, size 2592 written in the two-byte form, no payload
    blob_q = '{8'h00, 8'h02, kbhv_pkg::PREFIX_U16, 8'h20, 8'h0A};
    send_blob();

    write_regs(8'hA5, 8'h10, 8'h10, 8'hFF, 16'd2, 16'd0, 16'd253);
    // duplicate level code resolves to small, exact payload
    blob_q = '{8'hA5, 8'h10, 8'h02, 8'h00, 8'hFF};
    send_blob();
    blob_q = '{8'h00};
    send_blob();
    // 253 in the two-byte form, payload missing
    blob_q = '{8'hA5, 8'hFF, kbhv_pkg::PREFIX_U16, 8'hFD, 8'h00};
    send_blob();
    // 252 in the two-byte form is non-minimal
    blob_q = '{8'hA5, 8'hFF, kbhv_pkg::PREFIX_U16, 8'hFC, 8'h00};
    send_blob();
    // excess payload byte
    blob_q = '{8'hA5, 8'h10, 8'h02, 8'h11, 8'h22, 8'h33};
    send_blob();
    blob_q = '{8'hA5, 8'h77};
    send_blob();
    // last byte inside the length
    blob_q = '{8'hA5, 8'h10, kbhv_pkg::PREFIX_BASE + 8'd2};
    send_blob();

    goal = items_sent + RANDOM_ITEMS;
    phase_no = 0;
    while (items_sent < goal) begin
      case (phase_no)
        0: write_regs(8'hFF, 8'h00, 8'hFF, 8'h80, 16'd0, 16'hFFFF, 16'd253);
        1: write_regs(8'h00, 8'hFF, 8'h00, 8'h00, 16'hFFFF, 16'd1, 16'd252);
        2: write_regs(8'h00, 8'h00, 8'h01, 8'h02, 16'd1312, 16'd1952, 16'd2592);
        default: begin
          ls = 8'($urandom);
          lm = ($urandom_range(0, 4) == 0) ? ls : 8'($urandom);
          ll = ($urandom_range(0, 4) == 0) ? lm : 8'($urandom);
          write_regs(8'($urandom), ls, lm, ll, pick_size(), pick_size(), pick_size());
        end
      endcase
      calm = ($urandom_range(0, 3) == 0);
      if (phase_no % 3 == 1) holds_asked <= holds_asked + 1;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end && items_sent < goal) begin
        make_blob();
        send_blob();
        if ($urandom_range(0, 19) == 0) drain();
      end
      phase_no++;
    end

    drain();
    if (mismatches == 0 && beats_due == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
design/kbhv_pkg.sv
design/key_blob_header_validator.sv
tb/sv/kbhv_stream_checker.sv
tb/sv/tb_key_blob_header_validator.sv
